FILE: src/gbta_pkg.sv
// Shared constants, types and helper functions of the gradient b-tensor accumulator.
// No dependencies; every other file of the block but gbta_ram imports this package.
package gbta_pkg;

  localparam int MAX_SAMPLES = 4096;
  localparam int SAMPLE_BITS = 16;

  localparam int ADDR_W  = $clog2(MAX_SAMPLES);
  localparam int CNT_W   = $clog2(MAX_SAMPLES + 1);
  localparam int STORE_W = 3 * SAMPLE_BITS;
  // One amplitude-times-sample step: signed sample by a zero-extended 16-bit amplitude.
  localparam int STEP_W  = SAMPLE_BITS + 17;
  // The integrated moment stays below MAX_SAMPLES * 2^(SAMPLE_BITS+15) in magnitude.
  localparam int K_W     = ADDR_W + SAMPLE_BITS + 16;
  localparam int DIG_W   = 16;
  localparam int NDIG    = (K_W + DIG_W - 1) / DIG_W;
  localparam int MB_W    = NDIG * DIG_W;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 20;

  localparam logic [CFG_IDX_W-1:0] REG_AMP_PHASE = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_AMP_READ  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_AMP_SLICE = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_REFOC     = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_RASTER    = 3'd4;

  typedef struct packed {
    logic [CNT_W-1:0] count;
    logic             drop;
  } job_t;

  typedef struct packed {
    logic [62:0]        b_xx;
    logic [62:0]        b_yy;
    logic [62:0]        b_zz;
    logic signed [63:0] b_xy;
    logic signed [63:0] b_xz;
    logic signed [63:0] b_yz;
    logic [52:0]        crush_moment;
    logic               saturated;
    logic               overflowed;
  } res_t;

  function automatic logic signed [SAMPLE_BITS-1:0] to_sample(input logic signed [15:0] x);
    return SAMPLE_BITS'(x);
  endfunction

  // First and second axis of each of the six tensor products: xx yy zz xy xz yz.
  function automatic logic [1:0] prod_a(input logic [2:0] j);
    logic [1:0] r;
    case (j)
      3'd1:    r = 2'd1;
      3'd2:    r = 2'd2;
      3'd5:    r = 2'd1;
      default: r = 2'd0;
    endcase
    return r;
  endfunction

  function automatic logic [1:0] prod_b(input logic [2:0] j);
    logic [1:0] r;
    case (j)
      3'd1:    r = 2'd1;
      3'd3:    r = 2'd1;
      3'd2:    r = 2'd2;
      3'd4:    r = 2'd2;
      3'd5:    r = 2'd2;
      default: r = 2'd0;
    endcase
    return r;
  endfunction

endpackage

FILE: src/gbta_ram.sv
// Generic single-write, single-read memory with a registered read port.
// No dependencies.
module gbta_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

FILE: src/gbta_front.sv
// Front end: takes waveform samples, writes them to the sample store and hands over a job.
// Depends on gbta_pkg.
module gbta_front
  import gbta_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     push,
  output logic                     full,
  input  logic signed [15:0]       grad_phase,
  input  logic signed [15:0]       grad_read,
  input  logic signed [15:0]       grad_slice,
  input  logic                     last_sample,
  output logic                     wr_en,
  output logic [ADDR_W-1:0]        wr_addr,
  output logic [STORE_W-1:0]       wr_data,
  output logic                     job_valid,
  output job_t                     job,
  input  logic                     job_done
);

  logic [CNT_W-1:0] count;
  logic             drop;
  logic             accept;
  logic             room;

  // The store belongs to the back end until it releases the job.
  assign full    = job_valid;
  assign accept  = push && !job_valid;
  assign room    = count != CNT_W'(MAX_SAMPLES);
  assign wr_en   = accept && room;
  assign wr_addr = count[ADDR_W-1:0];
  assign wr_data = {to_sample(grad_phase), to_sample(grad_read), to_sample(grad_slice)};

  always_ff @(posedge clk) begin
    if (rst) begin
      count     <= '0;
      drop      <= 1'b0;
      job_valid <= 1'b0;
    end else begin
      if (job_done) begin
        job_valid <= 1'b0;
      end
      if (accept) begin
        if (last_sample) begin
          job_valid  <= 1'b1;
          job.count  <= room ? count + 1'b1 : count;
          job.drop   <= drop || !room;
          count      <= '0;
          drop       <= 1'b0;
        end else if (room) begin
          count <= count + 1'b1;
        end else begin
          drop <= 1'b1;
        end
      end
    end
  end

endmodule

FILE: src/gbta_mulsat.sv
// Saturating signed multiplier, 64 bits by K_W bits, one 16-bit digit of the second operand a cycle.
// Depends on gbta_pkg.
module gbta_mulsat
  import gbta_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  start,
  input  logic signed [63:0]    a,
  input  logic signed [K_W-1:0] b,
  output logic                  done,
  output logic signed [63:0]    p,
  output logic                  sat
);

  localparam int ACC_W = 64 + MB_W;
  localparam int DC_W  = $clog2(NDIG + 1);

  logic [63:0]         ma;
  logic [MB_W-1:0]     mb;
  logic [ACC_W-1:0]    acc;
  logic                neg;
  logic                busy;
  logic [DC_W-1:0]     cnt;
  logic [63:0]         a_mag;
  logic [K_W-1:0]      b_mag;
  logic [63+DIG_W:0]   pp;
  logic [63:0]         low;

  assign a_mag = a[63] ? 64'(-a) : 64'(a);
  assign b_mag = b[K_W-1] ? K_W'(-b) : K_W'(b);
  assign pp    = (64 + DIG_W)'(ma) * (64 + DIG_W)'(mb[MB_W-1 -: DIG_W]);

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
        acc  <= '0;
        ma   <= a_mag;
        mb   <= MB_W'(b_mag);
        neg  <= a[63] ^ b[K_W-1];
      end else if (busy) begin
        // Most significant digit first, so the running sum only ever shifts left.
        acc <= (acc << DIG_W) + ACC_W'(pp);
        mb  <= mb << DIG_W;
        cnt <= cnt + 1'b1;
        if (cnt == DC_W'(NDIG - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // A negative product may reach 2^63 exactly; a positive one stops at 2^63-1.
  assign sat = (|acc[ACC_W-1:64]) || (acc[63] && (!neg || (|acc[62:0])));
  assign low = acc[63:0];
  always_comb begin
    if (sat) begin
      p = neg ? {1'b1, 63'd0} : {1'b0, {63{1'b1}}};
    end else begin
      p = neg ? signed'(-low) : signed'(low);
    end
  end

endmodule

FILE: src/gbta_isqrt.sv
// Iterative integer square root of a 64-bit value, one result bit per cycle.
// Depends on gbta_pkg only through the common import convention.
module gbta_isqrt
  import gbta_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [63:0] value,
  output logic        done,
  output logic [31:0] root
);

  logic [63:0] v;
  logic [63:0] res;
  logic [63:0] bitm;
  logic [63:0] trial;
  logic        busy;
  logic [4:0]  cnt;

  assign trial = res + bitm;
  assign root  = res[31:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
        v    <= value;
        res  <= '0;
        bitm <= 64'd1 << 62;
      end else if (busy) begin
        if (v >= trial) begin
          v   <= v - trial;
          res <= (res >> 1) + bitm;
        end else begin
          res <= res >> 1;
        end
        bitm <= bitm >> 2;
        cnt  <= cnt + 1'b1;
        if (cnt == 5'd31) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

FILE: src/gbta_div.sv
// Restoring divider for the refocusing step count: 20-bit dividend, 8-bit divisor.
// Depends on gbta_pkg only through the common import convention.
module gbta_div
  import gbta_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [19:0] num,
  input  logic [7:0]  den,
  output logic        valid,
  output logic [19:0] quo
);

  logic [19:0] n;
  logic [7:0]  d;
  logic [7:0]  rem;
  logic [8:0]  trial;
  logic        ge;
  logic        busy;
  logic [4:0]  cnt;

  assign trial = {rem, n[19]};
  assign ge    = trial >= {1'b0, d};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      valid <= 1'b0;
    end else begin
      if (start) begin
        busy  <= 1'b1;
        valid <= 1'b0;
        cnt   <= '0;
        n     <= num;
        d     <= den;
        rem   <= '0;
        quo   <= '0;
      end else if (busy) begin
        rem <= ge ? 8'(trial - {1'b0, d}) : trial[7:0];
        quo <= {quo[18:0], ge};
        n   <= n << 1;
        cnt <= cnt + 1'b1;
        if (cnt == 5'd19) begin
          busy  <= 1'b0;
          valid <= 1'b1;
        end
      end
    end
  end

endmodule

FILE: src/gbta_back.sv
// Back end: runs both integration passes over the stored waveform, the crush root and
// the refocusing term. Depends on gbta_pkg, gbta_mulsat, gbta_isqrt and gbta_div.
module gbta_back
  import gbta_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  input  logic                job_valid,
  input  job_t                job,
  output logic                job_done,
  input  logic [15:0]         amp_phase,
  input  logic [15:0]         amp_read,
  input  logic [15:0]         amp_slice,
  input  logic [19:0]         refoc_duration_us,
  input  logic [7:0]          raster_time_us,
  output logic                rd_en,
  output logic [ADDR_W-1:0]   rd_addr,
  input  logic [STORE_W-1:0]  rd_data,
  input  logic                out_free,
  output logic                res_load,
  output res_t                res
);

  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_RD     = 4'd1;
  localparam logic [3:0] S_K      = 4'd2;
  localparam logic [3:0] S_M1     = 4'd3;
  localparam logic [3:0] S_W1     = 4'd4;
  localparam logic [3:0] S_M2     = 4'd5;
  localparam logic [3:0] S_W2     = 4'd6;
  localparam logic [3:0] S_ADD    = 4'd7;
  localparam logic [3:0] S_RSTART = 4'd8;
  localparam logic [3:0] S_ROOT   = 4'd9;
  localparam logic [3:0] S_DWAIT  = 4'd10;
  localparam logic [3:0] S_DONE   = 4'd11;

  localparam logic [1:0] PH_STEP  = 2'd0;
  localparam logic [1:0] PH_KSQ   = 2'd1;
  localparam logic [1:0] PH_REFOC = 2'd2;

  logic [3:0]              state;
  logic [1:0]              phase;
  logic                    pass2;
  logic [CNT_W-1:0]        idx;
  logic [2:0]              j;
  logic signed [K_W-1:0]   k [3];
  logic signed [63:0]      sums [6];
  logic signed [63:0]      sq;
  logic signed [63:0]      prod;
  logic                    sat;
  logic [39:0]             crush;
  logic [19:0]             times;
  logic [7:0]              raster_eff;

  logic signed [SAMPLE_BITS-1:0] smp [3];
  logic signed [STEP_W-1:0]      d [3];

  logic                    m_start;
  logic signed [63:0]      m_a;
  logic signed [K_W-1:0]   m_b;
  logic                    m_done;
  logic signed [63:0]      m_p;
  logic                    m_sat;

  logic                    r_done;
  logic [31:0]             r_root;
  logic                    dv_valid;
  logic [19:0]             dv_quo;

  logic signed [63:0]      tgt;
  logic signed [64:0]      s65;
  logic                    a_ovf;
  logic signed [63:0]      a_res;
  logic                    last_j;

  assign raster_eff = (raster_time_us == 8'd0) ? 8'd1 : raster_time_us;

  assign smp[0] = signed'(rd_data[STORE_W-1 -: SAMPLE_BITS]);
  assign smp[1] = signed'(rd_data[2*SAMPLE_BITS-1 -: SAMPLE_BITS]);
  assign smp[2] = signed'(rd_data[SAMPLE_BITS-1:0]);
  assign d[0]   = smp[0] * signed'({1'b0, amp_phase});
  assign d[1]   = smp[1] * signed'({1'b0, amp_read});
  assign d[2]   = smp[2] * signed'({1'b0, amp_slice});

  assign rd_en   = (state == S_RD) && (idx != job.count);
  assign rd_addr = idx[ADDR_W-1:0];

  assign m_start = (state == S_M1) || (state == S_M2);
  assign m_a     = (state == S_M2) ? prod : 64'(k[prod_a(j)]);
  assign m_b     = (state == S_M2) ? signed'(K_W'(times)) : k[prod_b(j)];

  gbta_mulsat u_mul (
    .clk   (clk),
    .rst   (rst),
    .start (m_start),
    .a     (m_a),
    .b     (m_b),
    .done  (m_done),
    .p     (m_p),
    .sat   (m_sat)
  );

  gbta_isqrt u_root (
    .clk   (clk),
    .rst   (rst),
    .start (state == S_RSTART),
    .value (sq),
    .done  (r_done),
    .root  (r_root)
  );

  gbta_div u_div (
    .clk   (clk),
    .rst   (rst),
    .start ((state == S_IDLE) && job_valid),
    .num   (refoc_duration_us),
    .den   (raster_eff),
    .valid (dv_valid),
    .quo   (dv_quo)
  );

  // Saturating accumulate of the finished product into its tensor sum or into |k|^2.
  assign tgt    = (phase == PH_KSQ) ? sq : sums[j];
  assign s65    = {tgt[63], tgt} + {prod[63], prod};
  assign a_ovf  = s65[64] != s65[63];
  assign a_res  = a_ovf ? (s65[64] ? {1'b1, 63'd0} : {1'b0, {63{1'b1}}}) : s65[63:0];
  assign last_j = (phase == PH_KSQ) ? (j == 3'd2) : (j == 3'd5);

  assign res_load = (state == S_DONE) && out_free;
  assign job_done = res_load;

  assign res.b_xx         = sums[0][62:0];
  assign res.b_yy         = sums[1][62:0];
  assign res.b_zz         = sums[2][62:0];
  assign res.b_xy         = sums[3];
  assign res.b_xz         = sums[4];
  assign res.b_yz         = sums[5];
  assign res.crush_moment = 53'(crush);
  assign res.saturated    = sat;
  assign res.overflowed   = job.drop;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (job_valid) begin
            for (int i = 0; i < 3; i++) begin
              k[i] <= '0;
            end
            for (int i = 0; i < 6; i++) begin
              sums[i] <= '0;
            end
            sq    <= '0;
            sat   <= 1'b0;
            idx   <= '0;
            pass2 <= 1'b0;
            state <= S_RD;
          end
        end
        S_RD: begin
          if (idx != job.count) begin
            state <= S_K;
          end else if (!pass2) begin
            phase <= PH_KSQ;
            j     <= '0;
            state <= S_M1;
          end else begin
            state <= S_DONE;
          end
        end
        S_K: begin
          for (int i = 0; i < 3; i++) begin
            k[i] <= pass2 ? k[i] + K_W'(d[i]) : k[i] - K_W'(d[i]);
          end
          idx   <= idx + 1'b1;
          phase <= PH_STEP;
          j     <= '0;
          state <= S_M1;
        end
        S_M1: begin
          state <= S_W1;
        end
        S_W1: begin
          if (m_done) begin
            prod  <= m_p;
            sat   <= sat || m_sat;
            state <= (phase == PH_REFOC && times != 20'd1) ? S_M2 : S_ADD;
          end
        end
        S_M2: begin
          state <= S_W2;
        end
        S_W2: begin
          if (m_done) begin
            prod  <= m_p;
            sat   <= sat || m_sat;
            state <= S_ADD;
          end
        end
        S_ADD: begin
          if (phase == PH_KSQ) begin
            sq <= a_res;
          end else begin
            sums[j] <= a_res;
          end
          sat <= sat || a_ovf;
          j   <= j + 1'b1;
          if (!last_j) begin
            state <= S_M1;
          end else if (phase == PH_STEP) begin
            state <= S_RD;
          end else if (phase == PH_KSQ) begin
            state <= S_RSTART;
          end else begin
            pass2 <= 1'b1;
            idx   <= '0;
            state <= S_RD;
          end
        end
        S_RSTART: begin
          state <= S_ROOT;
        end
        S_ROOT: begin
          if (r_done) begin
            crush <= 40'(r_root) * 40'(raster_eff);
            state <= S_DWAIT;
          end
        end
        S_DWAIT: begin
          if (dv_valid) begin
            times <= dv_quo;
            phase <= PH_REFOC;
            j     <= '0;
            state <= S_M1;
          end
        end
        S_DONE: begin
          if (out_free) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

FILE: src/gradient_b_tensor_accumulator_unit.sv
// Top level of the gradient b-tensor accumulator: configuration registers, sample store,
// front and back ends and the result register. Depends on gbta_pkg and all gbta_ modules.
//
// Use: samples of a three-axis gradient waveform are pushed on the input queue side
// (push, full), one per cycle while full is low, until a sample carries last_sample.
// That sample starts the computation and full stays high until the back end has
// finished with the stored waveform and placed the result in the output register.
// Waveforms without a last sample give no result. The result is read from the output
// queue side (empty, pop); while it waits to be popped the next waveform may already
// be loaded and computed, and only the final hand-over waits for the output register
// to drain. Configuration is written through cfg_valid/cfg_ready (always ready),
// indexed by cfg_index, and must only change while no waveform is in flight.
// Each of the two passes over the stored samples is paced by the single shared
// digit-serial saturating multiplier; the |k|^2 sum, the crush root and the
// refocusing term are computed between the first and the second pass.
// Reset (synchronous, active high) empties the queues and restores register defaults;
// the sample store needs no clearing since only freshly written entries are read.
module gradient_b_tensor_accumulator_unit
  import gbta_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  push,
  output logic                  full,
  input  logic signed [15:0]    grad_phase,
  input  logic signed [15:0]    grad_read,
  input  logic signed [15:0]    grad_slice,
  input  logic                  last_sample,
  output logic                  empty,
  input  logic                  pop,
  output logic [62:0]           b_xx,
  output logic [62:0]           b_yy,
  output logic [62:0]           b_zz,
  output logic signed [63:0]    b_xy,
  output logic signed [63:0]    b_xz,
  output logic signed [63:0]    b_yz,
  output logic [52:0]           crush_moment,
  output logic                  saturated,
  output logic                  overflowed,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  logic [15:0] amp_phase;
  logic [15:0] amp_read;
  logic [15:0] amp_slice;
  logic [19:0] refoc_duration_us;
  logic [7:0]  raster_time_us;

  logic               wr_en;
  logic [ADDR_W-1:0]  wr_addr;
  logic [STORE_W-1:0] wr_data;
  logic               rd_en;
  logic [ADDR_W-1:0]  rd_addr;
  logic [STORE_W-1:0] rd_data;

  logic job_valid;
  job_t job;
  logic job_done;

  logic out_valid;
  res_t out_q;
  res_t res;
  logic res_load;

  // Register writes are always taken; unknown indexes are ignored.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      amp_phase         <= '0;
      amp_read          <= '0;
      amp_slice         <= '0;
      refoc_duration_us <= '0;
      raster_time_us    <= 8'd10;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_AMP_PHASE: amp_phase         <= cfg_data[15:0];
        REG_AMP_READ:  amp_read          <= cfg_data[15:0];
        REG_AMP_SLICE: amp_slice         <= cfg_data[15:0];
        REG_REFOC:     refoc_duration_us <= cfg_data;
        REG_RASTER:    raster_time_us    <= cfg_data[7:0];
        default: begin
        end
      endcase
    end
  end

  gbta_front u_front (
    .clk         (clk),
    .rst         (rst),
    .push        (push),
    .full        (full),
    .grad_phase  (grad_phase),
    .grad_read   (grad_read),
    .grad_slice  (grad_slice),
    .last_sample (last_sample),
    .wr_en       (wr_en),
    .wr_addr     (wr_addr),
    .wr_data     (wr_data),
    .job_valid   (job_valid),
    .job         (job),
    .job_done    (job_done)
  );

  gbta_ram #(
    .WIDTH (STORE_W),
    .DEPTH (MAX_SAMPLES)
  ) u_store (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  gbta_back u_back (
    .clk               (clk),
    .rst               (rst),
    .job_valid         (job_valid),
    .job               (job),
    .job_done          (job_done),
    .amp_phase         (amp_phase),
    .amp_read          (amp_read),
    .amp_slice         (amp_slice),
    .refoc_duration_us (refoc_duration_us),
    .raster_time_us    (raster_time_us),
    .rd_en             (rd_en),
    .rd_addr           (rd_addr),
    .rd_data           (rd_data),
    .out_free          (!out_valid),
    .res_load          (res_load),
    .res               (res)
  );

  // One-deep output register; the back end only loads it when it is empty.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res_load) begin
      out_valid <= 1'b1;
    end else if (pop) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_load) begin
      out_q <= res;
    end
  end

  assign empty        = !out_valid;
  assign b_xx         = out_q.b_xx;
  assign b_yy         = out_q.b_yy;
  assign b_zz         = out_q.b_zz;
  assign b_xy         = out_q.b_xy;
  assign b_xz         = out_q.b_xz;
  assign b_yz         = out_q.b_yz;
  assign crush_moment = out_q.crush_moment;
  assign saturated    = out_q.saturated;
  assign overflowed   = out_q.overflowed;

  // A result is never loaded over one that is still waiting.
  a_load_free: assert property (@(posedge clk) disable iff (rst) res_load |-> !out_valid)
    else $error("result loaded into an occupied output register");

  // The back end only releases a waveform that the front end handed over.
  a_done_held: assert property (@(posedge clk) disable iff (rst) job_done |-> job_valid)
    else $error("job released without a pending job");

  // The store is never written while the back end owns it.
  a_no_write: assert property (@(posedge clk) disable iff (rst) job_valid |-> !wr_en)
    else $error("sample store written during computation");

  // A popped result leaves the output side empty unless a new one arrives.
  a_pop_empty: assert property (@(posedge clk) disable iff (rst)
    (pop && !empty && !res_load) |=> empty)
    else $error("output register not emptied by pop");

endmodule
